FILE: rtl/nfta_pkg.sv
`default_nettype none

package nfta_pkg;

   // Input coordinate and gradient width, signed Q16.16.
   localparam int COORD_W = 32;
   // Fraction bits of the Q16.16 format.
   localparam int FRAC_W = 16;
   // Accumulator and result field width.
   localparam int ACC_W = 48;
   // Default saturation width of a lever component.
   localparam int COORD_WIDTH_DEF = 32;
   // Result buffer depth, a power of two.
   localparam int RESULT_DEPTH = 4;

   localparam int REQ_DATA_W = 6 * COORD_W;
   localparam int RSP_DATA_W = 6 * ACC_W;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      REG_CENTRE_X = 2'd0,
      REG_CENTRE_Y = 2'd1,
      REG_CENTRE_Z = 2'd2,
      REG_NONE     = 2'd3
   } reg_index_type;

endpackage

`default_nettype wire

FILE: rtl/net_force_torque_accumulator_top.sv
`default_nettype none
// Net force and torque accumulator for one rigid molecule.
//
// The req channel carries one atom per item: position and gradient, each
// a signed Q16.16 triple, with tlast marking the final atom of a molecule.
// Each atom's gradient is summed into three force accumulators, and the
// cross product of its lever (position minus the centre of mass, clamped
// to COORD_WIDTH bits) with its gradient, rescaled to Q16.16, is summed
// into three torque accumulators. All six are 48-bit and saturate.
// On the atom with tlast set, the six sums including that atom go out as
// one item on the rsp channel and the accumulators clear.
// The centre of mass is set through the csr port; the user must write it
// only while the block is idle, which the block itself does not enforce.
// Throughput is one atom per cycle while req_tready is high. The datapath
// is a four-stage pipeline (input register, lever, multiply, cross
// difference) ahead of the accumulate stage, which pushes each result into
// a four-deep buffer. req_tready drops only while four molecules are
// finished or in flight but not yet taken, so a stalled receiver holds the
// block only once that buffer is committed. Reset clears the accumulators,
// the centre registers, the pipeline and the buffer.
module net_force_torque_accumulator_top #(
   parameter int COORD_WIDTH = nfta_pkg::COORD_WIDTH_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // req_tdata, from bit 0: pos_x, pos_y, pos_z, grad_x, grad_y, grad_z
   input  wire logic [nfta_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  wire logic                                 req_tlast,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // rsp_tdata, from bit 0: force_x, force_y, force_z,
   // torque_x, torque_y, torque_z
   output logic [nfta_pkg::RSP_DATA_W-1:0]           rsp_tdata,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [nfta_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire logic [nfta_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [nfta_pkg::CSR_DATA_W-1:0]           csr_prdata,
   output logic                                      csr_pready
);
   import nfta_pkg::*;

   // A difference of two coordinates needs one bit more than a coordinate;
   // a lever never needs more than that.
   localparam int DIFF_W = COORD_W + 1;
   localparam int LEV_W = (COORD_WIDTH < DIFF_W) ? COORD_WIDTH : DIFF_W;
   localparam int PROD_W = LEV_W + COORD_W;
   localparam int SCL_W = PROD_W - FRAC_W;
   localparam int DELTA_W = SCL_W + 1;
   localparam int SUM_W = ((DELTA_W > ACC_W) ? DELTA_W : ACC_W) + 1;
   localparam int PTR_W = $clog2(RESULT_DEPTH);
   localparam int CNT_W = $clog2(RESULT_DEPTH + 1);

   localparam logic signed [DIFF_W-1:0] LEV_MAX =
      signed'({{(DIFF_W - LEV_W + 1){1'b0}}, {(LEV_W - 1){1'b1}}});
   localparam logic signed [DIFF_W-1:0] LEV_MIN = ~LEV_MAX;
   localparam logic signed [SUM_W-1:0] ACC_MAX =
      signed'({{(SUM_W - ACC_W + 1){1'b0}}, {(ACC_W - 1){1'b1}}});
   localparam logic signed [SUM_W-1:0] ACC_MIN = ~ACC_MAX;
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(RESULT_DEPTH);

   // Saturating add of a widened delta onto a 48-bit accumulator.
   function automatic logic signed [ACC_W-1:0] sat_add(
      input logic signed [ACC_W-1:0] acc,
      input logic signed [SUM_W-1:0] delta
   );
      logic signed [SUM_W-1:0] sum;
      sum = signed'({{(SUM_W - ACC_W){acc[ACC_W-1]}}, acc}) + delta;
      if (sum > ACC_MAX) begin
         return ACC_MAX[ACC_W-1:0];
      end else if (sum < ACC_MIN) begin
         return ACC_MIN[ACC_W-1:0];
      end
      return sum[ACC_W-1:0];
   endfunction

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic signed [COORD_W-1:0] centre_ff [3];
   logic                      csr_wr;
   reg_index_type             csr_idx;

   assign csr_pready = 1'b1;
   assign csr_idx    = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         centre_ff[0] <= '0;
         centre_ff[1] <= '0;
         centre_ff[2] <= '0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_CENTRE_X: centre_ff[0] <= csr_pwdata[COORD_W-1:0];
            REG_CENTRE_Y: centre_ff[1] <= csr_pwdata[COORD_W-1:0];
            REG_CENTRE_Z: centre_ff[2] <= csr_pwdata[COORD_W-1:0];
            REG_NONE:     ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_CENTRE_X: csr_prdata = CSR_DATA_W'(unsigned'(centre_ff[0]));
         REG_CENTRE_Y: csr_prdata = CSR_DATA_W'(unsigned'(centre_ff[1]));
         REG_CENTRE_Z: csr_prdata = CSR_DATA_W'(unsigned'(centre_ff[2]));
         REG_NONE:     csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Admission: count molecules accepted but not yet delivered so the
   // result buffer can never overflow.
   // ------------------------------------------------------------------
   logic [CNT_W-1:0] pend_ff;
   logic [CNT_W-1:0] pend_in;
   logic             req_acc;
   logic             rsp_pop;

   assign req_tready = (pend_ff < DEPTH_CNT);
   assign req_acc    = req_tvalid & req_tready;
   assign rsp_pop    = rsp_tvalid & rsp_tready;

   always_comb begin
      pend_in = pend_ff;
      if (req_acc && req_tlast) begin
         pend_in = pend_in + CNT_W'(1);
      end
      if (rsp_pop) begin
         pend_in = pend_in - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: input register
   // ------------------------------------------------------------------
   logic                      s1_vld_ff;
   logic                      s1_last_ff;
   logic signed [COORD_W-1:0] s1_pos_ff  [3];
   logic signed [COORD_W-1:0] s1_grad_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= req_acc;
      end
   end

   always_ff @(posedge clock) begin
      s1_last_ff <= req_tlast;
      for (int i = 0; i < 3; i++) begin
         s1_pos_ff[i]  <= req_tdata[i*COORD_W +: COORD_W];
         s1_grad_ff[i] <= req_tdata[(i+3)*COORD_W +: COORD_W];
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: lever = position - centre, clamped to LEV_W bits
   // ------------------------------------------------------------------
   logic                      s2_vld_ff;
   logic                      s2_last_ff;
   logic signed [LEV_W-1:0]   s2_lev_ff  [3];
   logic signed [LEV_W-1:0]   s2_lev_in  [3];
   logic signed [COORD_W-1:0] s2_grad_ff [3];
   logic signed [DIFF_W-1:0]  s2_diff    [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s2_diff[i] = signed'({s1_pos_ff[i][COORD_W-1], s1_pos_ff[i]})
                    - signed'({centre_ff[i][COORD_W-1], centre_ff[i]});
         if (s2_diff[i] > LEV_MAX) begin
            s2_lev_in[i] = LEV_MAX[LEV_W-1:0];
         end else if (s2_diff[i] < LEV_MIN) begin
            s2_lev_in[i] = LEV_MIN[LEV_W-1:0];
         end else begin
            s2_lev_in[i] = s2_diff[i][LEV_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_last_ff <= s1_last_ff;
      s2_lev_ff  <= s2_lev_in;
      s2_grad_ff <= s1_grad_ff;
   end

   // ------------------------------------------------------------------
   // Stage 3: six lever x gradient products, rescaled by flooring shift.
   // Order: a1*g2, a2*g1, a2*g0, a0*g2, a0*g1, a1*g0.
   // ------------------------------------------------------------------
   logic                      s3_vld_ff;
   logic                      s3_last_ff;
   logic signed [SCL_W-1:0]   s3_prod_ff [6];
   logic signed [SCL_W-1:0]   s3_prod_in [6];
   logic signed [PROD_W-1:0]  s3_full    [6];
   logic signed [COORD_W-1:0] s3_grad_ff [3];

   always_comb begin
      s3_full[0] = s2_lev_ff[1] * s2_grad_ff[2];
      s3_full[1] = s2_lev_ff[2] * s2_grad_ff[1];
      s3_full[2] = s2_lev_ff[2] * s2_grad_ff[0];
      s3_full[3] = s2_lev_ff[0] * s2_grad_ff[2];
      s3_full[4] = s2_lev_ff[0] * s2_grad_ff[1];
      s3_full[5] = s2_lev_ff[1] * s2_grad_ff[0];
      for (int i = 0; i < 6; i++) begin
         s3_prod_in[i] = s3_full[i][PROD_W-1:FRAC_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_last_ff <= s2_last_ff;
      s3_prod_ff <= s3_prod_in;
      s3_grad_ff <= s2_grad_ff;
   end

   // ------------------------------------------------------------------
   // Stage 4: cross product components
   // ------------------------------------------------------------------
   logic                      s4_vld_ff;
   logic                      s4_last_ff;
   logic signed [DELTA_W-1:0] s4_tq_ff   [3];
   logic signed [DELTA_W-1:0] s4_tq_in   [3];
   logic signed [COORD_W-1:0] s4_grad_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s4_tq_in[i] =
            signed'({s3_prod_ff[2*i][SCL_W-1], s3_prod_ff[2*i]})
          - signed'({s3_prod_ff[2*i+1][SCL_W-1], s3_prod_ff[2*i+1]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else begin
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s4_last_ff <= s3_last_ff;
      s4_tq_ff   <= s4_tq_in;
      s4_grad_ff <= s3_grad_ff;
   end

   // ------------------------------------------------------------------
   // Accumulate stage: saturating sums; the last atom pushes the result
   // into the buffer and clears the sums.
   // ------------------------------------------------------------------
   logic signed [ACC_W-1:0] force_ff     [3];
   logic signed [ACC_W-1:0] torque_ff    [3];
   logic signed [ACC_W-1:0] force_sum    [3];
   logic signed [ACC_W-1:0] torque_sum   [3];
   logic [RSP_DATA_W-1:0]   push_data;
   logic                    push;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         force_sum[i] = sat_add(force_ff[i],
            signed'({{(SUM_W - COORD_W){s4_grad_ff[i][COORD_W-1]}},
                     s4_grad_ff[i]}));
         torque_sum[i] = sat_add(torque_ff[i],
            signed'({{(SUM_W - DELTA_W){s4_tq_ff[i][DELTA_W-1]}},
                     s4_tq_ff[i]}));
         push_data[i*ACC_W +: ACC_W]     = force_sum[i];
         push_data[(i+3)*ACC_W +: ACC_W] = torque_sum[i];
      end
   end

   assign push = s4_vld_ff & s4_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            force_ff[i]  <= '0;
            torque_ff[i] <= '0;
         end
      end else if (s4_vld_ff) begin
         for (int i = 0; i < 3; i++) begin
            if (s4_last_ff) begin
               force_ff[i]  <= '0;
               torque_ff[i] <= '0;
            end else begin
               force_ff[i]  <= force_sum[i];
               torque_ff[i] <= torque_sum[i];
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Result buffer
   // ------------------------------------------------------------------
   logic [RSP_DATA_W-1:0] buf_ff [RESULT_DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff;
   logic [PTR_W-1:0]      rd_ptr_ff;
   logic [CNT_W-1:0]      buf_cnt_ff;
   logic [CNT_W-1:0]      buf_cnt_in;

   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_comb begin
      buf_cnt_in = buf_cnt_ff;
      if (push) begin
         buf_cnt_in = buf_cnt_in + CNT_W'(1);
      end
      if (rsp_pop) begin
         buf_cnt_in = buf_cnt_in - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         buf_cnt_ff <= '0;
      end else begin
         buf_cnt_ff <= buf_cnt_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (rsp_pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
      end
   end

   assign rsp_tvalid = (buf_cnt_ff != '0);
   assign rsp_tdata  = buf_ff[rd_ptr_ff];

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= DEPTH_CNT)
      else $error("pending molecule count exceeds buffer depth");

   a_buf_within_pend: assert property (@(posedge clock) disable iff (reset)
      buf_cnt_ff <= pend_ff)
      else $error("buffered results exceed pending molecules");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (buf_cnt_ff < DEPTH_CNT) || rsp_pop)
      else $error("result pushed into a full buffer");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      push |=> (force_ff[0] == '0) && (force_ff[1] == '0)
            && (force_ff[2] == '0) && (torque_ff[0] == '0)
            && (torque_ff[1] == '0) && (torque_ff[2] == '0))
      else $error("accumulators not cleared after last atom");

endmodule

`default_nettype wire

FILE: tb/net_force_torque_accumulator_top_test.sv
`default_nettype none

// Self-checking bench for the net force and torque accumulator.
//
// Atoms go in on the req stream, one item per atom, and every molecule closes
// with tlast. A behavioral copy of the accumulator runs beside the block: it
// keeps its own centre of mass and its own six saturating sums, and whenever
// an atom with tlast is accepted it queues the sums that the block must send.
// Every item taken from the rsp stream is compared field by field with the
// oldest queued entry.
//
// The stimulus runs in three parts. A short table of hand-picked atoms covers
// the reset state, field extremes, the floor rounding of the lever rescale,
// torque saturation in both directions, accumulation from a clamped sum, and
// lever clamping against an extreme centre. Then come several phases of random
// molecules, each under its own centre setting. Last, one long molecule with
// full-scale gradients builds large sums, and a short molecule after it shows
// that the sums cleared.
module net_force_torque_accumulator_top_test;
   import nfta_pkg::*;

   localparam int COORD_WIDTH = COORD_WIDTH_DEF;
   localparam int CLOCK_PERIOD = 8;
   localparam int RESET_CYCLES = 7;
   // Idle margin after the last result so that no atom is still in flight.
   localparam int DRAIN_CYCLES = 16;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_ITEMS = 220;
   // Length of the closing molecule with full-scale gradients.
   localparam int LONG_ATOMS = 120;

   localparam logic [COORD_W-1:0] Q_MAX = 32'h7FFF_FFFF;
   localparam logic [COORD_W-1:0] Q_MIN = 32'h8000_0000;
   localparam logic [COORD_W-1:0] Q_ONE = 32'h0001_0000;
   localparam logic [COORD_W-1:0] Q_NEG_LSB = 32'hFFFF_FFFF;

   localparam longint ACC_HI = (longint'(1) <<< (ACC_W - 1)) - 1;
   localparam longint ACC_LO = -ACC_HI - 1;
   localparam longint LEVER_HI = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
   localparam longint LEVER_LO = -LEVER_HI - 1;

   // One atom as it travels on req_tdata and req_tlast.
   typedef struct packed {
      logic                     last;
      logic [2:0][COORD_W-1:0]  grad;
      logic [2:0][COORD_W-1:0]  pos;
   } atom_type;

   // The six sums in rsp_tdata order: force x, y, z, then torque x, y, z.
   typedef logic [5:0][ACC_W-1:0] sums_type;

   // A row of the directed table. Where typed is set, the sums were worked
   // out by hand and are expected instead of the predicted ones.
   typedef struct packed {
      logic      recentre;
      logic      typed;
      sums_type  sums;
      atom_type  atom;
   } directed_row_type;

   typedef enum {
      STREAM_READY,
      COIN_FLIP,
      TRICKLE,
      LONG_HOLD
   } stall_kind_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tlast = 1'b0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Predictor state: the centre of mass and the six running sums.
   longint centre [3] = '{0, 0, 0};
   longint force_acc [3] = '{0, 0, 0};
   longint torque_acc [3] = '{0, 0, 0};

   sums_type pending_sums [$];
   directed_row_type directed_rows [$];
   string field_name [6] = '{"force_x", "force_y", "force_z",
                             "torque_x", "torque_y", "torque_z"};
   int mismatches = 0;

   // Sender burst bookkeeping and receiver stall pattern.
   int burst_left = 0;
   stall_kind_type stall_mode = STREAM_READY;
   int mode_left = 0;
   int hold_left = 0;

   net_force_torque_accumulator_top #(
      .COORD_WIDTH(COORD_WIDTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #(CLOCK_PERIOD / 2) clock = 1'b1;
      #(CLOCK_PERIOD / 2) clock = 1'b0;
   end

   function automatic longint clamp(input longint v, input longint lo, input longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // Exact product shifted down by the fraction width; the arithmetic shift
   // rounds toward minus infinity.
   function automatic longint rescaled(input longint a, input longint g);
      return (a * g) >>> FRAC_W;
   endfunction

   function automatic void set_centre(input reg_index_type idx,
                                      input logic [CSR_DATA_W-1:0] value);
      case (idx)
         REG_CENTRE_X: centre[0] = longint'($signed(value));
         REG_CENTRE_Y: centre[1] = longint'($signed(value));
         REG_CENTRE_Z: centre[2] = longint'($signed(value));
         default: ;
      endcase
   endfunction

   // Folds one atom into the running sums. Returns 1 with the six sums when
   // the atom closes its molecule, and clears the sums in that case.
   function automatic bit accumulate_atom(input atom_type atom, output sums_type sums);
      longint lever [3];
      longint grad [3];
      longint turn [3];
      for (int i = 0; i < 3; i++) begin
         lever[i] = clamp(longint'($signed(atom.pos[i])) - centre[i], LEVER_LO, LEVER_HI);
         grad[i] = longint'($signed(atom.grad[i]));
         force_acc[i] = clamp(force_acc[i] + grad[i], ACC_LO, ACC_HI);
      end
      turn[0] = rescaled(lever[1], grad[2]) - rescaled(lever[2], grad[1]);
      turn[1] = rescaled(lever[2], grad[0]) - rescaled(lever[0], grad[2]);
      turn[2] = rescaled(lever[0], grad[1]) - rescaled(lever[1], grad[0]);
      for (int i = 0; i < 3; i++) begin
         torque_acc[i] = clamp(torque_acc[i] + turn[i], ACC_LO, ACC_HI);
      end
      sums = '0;
      if (!atom.last) return 1'b0;
      for (int i = 0; i < 3; i++) begin
         sums[i] = ACC_W'(force_acc[i]);
         sums[3 + i] = ACC_W'(torque_acc[i]);
         force_acc[i] = 0;
         torque_acc[i] = 0;
      end
      return 1'b1;
   endfunction

   function automatic sums_type sums_of(input logic [ACC_W-1:0] fx, fy, fz, tx, ty, tz);
      return {tz, ty, tx, fz, fy, fx};
   endfunction

   function automatic void add_row(input logic [COORD_W-1:0] px, py, pz, gx, gy, gz,
                                   input logic last, recentre, typed,
                                   input sums_type sums);
      directed_row_type r;
      r.atom.pos = {pz, py, px};
      r.atom.grad = {gz, gy, gx};
      r.atom.last = last;
      r.recentre = recentre;
      r.typed = typed;
      r.sums = sums;
      directed_rows.push_back(r);
   endfunction

   // Full-range values half the time, with the extremes, zero and small
   // magnitudes drawn often enough to matter.
   function automatic logic [COORD_W-1:0] rand_coord();
      case ($urandom_range(0, 9))
         0: return Q_MAX;
         1: return Q_MIN;
         2: return '0;
         3, 4: return COORD_W'($urandom_range(0, 32'h20_0000)) - 32'h10_0000;
         default: return $urandom();
      endcase
   endfunction

   function automatic atom_type random_atom(input logic last);
      atom_type a;
      for (int i = 0; i < 3; i++) begin
         a.pos[i] = rand_coord();
         a.grad[i] = rand_coord();
      end
      a.last = last;
      return a;
   endfunction

   // Compares one received item with the oldest queued sums.
   task automatic check_result(input sums_type got);
      sums_type want;
      if (pending_sums.size() == 0) begin
         $display("%0t: result item with nothing expected, got force_x %0d",
                  $time, $signed(got[0]));
         mismatches++;
         return;
      end
      want = pending_sums.pop_front();
      for (int i = 0; i < 6; i++) begin
         if (got[i] !== want[i]) begin
            $display("%0t: %s expected %0d, got %0d", $time, field_name[i],
                     $signed(want[i]), $signed(got[i]));
            mismatches++;
         end
      end
   endtask

   // Offers one atom, holding it until it is taken. The sender runs in
   // bursts; before each burst it may drop valid for a random gap.
   task automatic send_atom(input atom_type atom, input logic typed,
                            input sums_type typed_sums);
      sums_type predicted;
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 32);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= {atom.grad, atom.pos};
      req_tlast <= atom.last;
      do @(posedge clock); while (!req_tready);
      if (accumulate_atom(atom, predicted)) begin
         pending_sums.push_back(typed ? typed_sums : predicted);
      end
   endtask

   // Stops the sender, waits for every queued result, then lets the pipeline
   // run dry so that a register write cannot touch an atom still in flight.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_sums.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      set_centre(idx, value);
      @(posedge clock);
   endtask

   task automatic csr_read_check(input reg_index_type idx);
      logic [CSR_DATA_W-1:0] want;
      want = CSR_DATA_W'(centre[int'(idx)]);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== want) begin
         $display("%0t: %s read expected %0d, got %0d", $time, idx.name(),
                  $signed(want), $signed(csr_prdata));
         mismatches++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Sets all three centre registers, throws a write at the unused address,
   // which must change nothing, and reads the three back.
   task automatic program_centre(input logic [CSR_DATA_W-1:0] x, y, z);
      csr_write(REG_CENTRE_X, x);
      csr_write(REG_CENTRE_Y, y);
      csr_write(REG_CENTRE_Z, z);
      csr_write(REG_NONE, $urandom());
      csr_read_check(REG_CENTRE_X);
      csr_read_check(REG_CENTRE_Y);
      csr_read_check(REG_CENTRE_Z);
   endtask

   // The receiver switches between stall patterns at random intervals:
   // always ready, a coin flip, a rare ready, and long holds.
   always @(posedge clock) begin : result_monitor
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_result(rsp_tdata);
         if (mode_left == 0) begin
            stall_mode <= stall_kind_type'($urandom_range(0, 3));
            mode_left <= $urandom_range(16, 300);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            STREAM_READY: rsp_tready <= 1'b1;
            COIN_FLIP: rsp_tready <= ($urandom_range(0, 1) == 1);
            TRICKLE: rsp_tready <= ($urandom_range(0, 7) == 0);
            default: begin
               rsp_tready <= (hold_left == 0);
               hold_left <= (hold_left == 0) ? $urandom_range(5, 40) : hold_left - 1;
            end
         endcase
      end
   end

   initial begin : stimulus
      atom_type atom;
      int count;
      int span;

      // Right after reset the sums and the centre are zero.
      add_row(0, 0, 0, 0, 0, 0, 1, 0, 1, sums_of(0, 0, 0, 0, 0, 0));
      // Two full-scale gradients with the lever at zero: pure force.
      add_row(0, 0, 0, Q_MAX, Q_MAX, Q_MAX, 0, 0, 0, '0);
      add_row(0, 0, 0, Q_MAX, Q_MAX, Q_MAX, 1, 0, 1,
              sums_of(48'sd4294967294, 48'sd4294967294, 48'sd4294967294, 0, 0, 0));
      add_row(0, 0, 0, Q_MIN, Q_MIN, Q_MIN, 1, 0, 1,
              sums_of(-48'sd2147483648, -48'sd2147483648, -48'sd2147483648, 0, 0, 0));
      // Unit lever along x crossed with unit gradient along y gives unit z.
      add_row(Q_ONE, 0, 0, 0, Q_ONE, 0, 1, 0, 1, sums_of(0, 65536, 0, 0, 0, 65536));
      // The rescale floors: a product of minus one LSB stays at minus one.
      add_row(Q_NEG_LSB, 0, 0, 0, 1, 0, 1, 0, 1, sums_of(0, 1, 0, 0, 0, -48'sd1));
      add_row(1, 0, 0, 0, 1, 0, 1, 0, 1, sums_of(0, 1, 0, 0, 0, 0));
      add_row(Q_MAX, 0, 0, 0, Q_MAX, 0, 1, 0, 0, '0);
      add_row(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1, 0, 0, '0);
      // Torque x runs into the positive limit, then a negative step must
      // come off the clamped value.
      repeat (3) add_row(0, Q_MAX, Q_MIN, 0, Q_MAX, Q_MAX, 0, 0, 0, '0);
      add_row(0, Q_ONE, 0, 0, 0, Q_MIN, 1, 0, 0, '0);
      // The same toward the negative limit.
      repeat (3) add_row(0, Q_MIN, Q_MAX, 0, Q_MAX, Q_MAX, 0, 0, 0, '0);
      add_row(0, Q_ONE, 0, 0, 0, Q_MAX, 1, 0, 0, '0);
      // With the centre at one extreme corner, the levers of atoms at the opposite extremes clamp.
      add_row(Q_MAX, Q_MIN, Q_MAX, Q_MAX, Q_MIN, Q_MAX, 0, 1, 0, '0);
      add_row(Q_MIN, Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MIN, 0, 0, 0, '0);
      add_row(Q_MAX, Q_MIN, Q_MAX, Q_ONE, Q_ONE, Q_ONE, 1, 0, 0, '0);
      add_row(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_F0F0, 32'hAAAA_AAAA,
              32'h5555_5555, 32'hF0F0_0F0F, 1, 0, 0, '0);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].recentre) begin
            settle();
            program_centre(Q_MIN, Q_MAX, Q_MIN);
         end
         send_atom(directed_rows[i].atom, directed_rows[i].typed, directed_rows[i].sums);
      end

      // Random molecules, mostly short, some single-atom, some long. Each
      // phase runs under its own centre of mass.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle();
         case (phase)
            0: program_centre('0, '0, '0);
            1: program_centre(Q_MAX, Q_MAX, Q_MAX);
            2: program_centre(Q_MIN, Q_MIN, Q_MIN);
            default: program_centre(rand_coord(), rand_coord(), rand_coord());
         endcase
         count = 0;
         while (count < PHASE_ITEMS) begin
            case ($urandom_range(0, 3))
               0: span = 1;
               3: span = $urandom_range(7, 20);
               default: span = $urandom_range(2, 6);
            endcase
            for (int k = 0; k < span; k++) begin
               send_atom(random_atom(k == span - 1), 1'b0, '0);
            end
            count += span;
         end
      end

      // One long molecule with full-scale gradients builds large force and
      // torque sums; a few random atoms then continue from them. A short
      // molecule after it shows that the sums cleared.
      settle();
      program_centre('0, '0, '0);
      for (int k = 0; k < LONG_ATOMS; k++) begin
         atom = random_atom(1'b0);
         atom.grad[0] = Q_MAX;
         atom.grad[1] = Q_MIN;
         atom.grad[2] = Q_MAX;
         send_atom(atom, 1'b0, '0);
      end
      for (int k = 0; k < 4; k++) begin
         send_atom(random_atom(k == 3), 1'b0, '0);
      end
      send_atom(random_atom(1'b0), 1'b0, '0);
      send_atom(random_atom(1'b1), 1'b0, '0);

      settle();
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Far beyond the slowest legitimate run; reaching it means a hang.
   initial begin : watchdog
      #(CLOCK_PERIOD * 2_000_000);
      $display("status: fail");
      $finish;
   end

endmodule

`default_nettype wire
